@@ sv/acss_pkg.sv @@
package acss_pkg;

    // Default sizing, handed to the top level parameters
    localparam int CHANNELS_DEF    = 21;
    localparam int SAMPLE_BITS_DEF = 12;

    // Widths fixed by the word formats
    localparam int SAMPLE_W    = 12;
    localparam int CHAN_W      = 5;
    localparam int MS_W        = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int SAMPLE_W_MAX = 16;

    // Register map, selected by paddr[2]
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_GAP     = 1'b1;

    // Reset values of the registers
    localparam logic [MS_W-1:0] TIMEOUT_RST = 16'd100;
    localparam logic [MS_W-1:0] GAP_RST     = 16'd1000;

    // Command codes
    typedef enum logic [1:0] {
        CMD_POLL = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DONE = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    // Reported phase codes
    localparam logic [1:0] PHASE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_START = 2'd1;
    localparam logic [1:0] PHASE_WAIT  = 2'd2;
    localparam logic [1:0] PHASE_DONE  = 2'd3;

    // Scan state machine, one-hot
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // Input word
    typedef struct packed {
        t_cmd                cmd;
        logic [SAMPLE_W-1:0] sample;
        logic [CHAN_W-1:0]   read_channel;
        logic                clear_new;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic                start_conversion;
        logic [CHAN_W-1:0]   conversion_channel;
        logic [1:0]          phase;
        logic                scan_complete;
        logic                timed_out;
        logic [SAMPLE_W-1:0] read_sample;
        logic                read_new;
    } t_out_word;

    // Timing settings from the register block
    typedef struct packed {
        logic [MS_W-1:0] timeout_ms;
        logic [MS_W-1:0] gap_ms;
    } t_cfg;

endpackage

@@ sv/adc_channel_scan_sequencer.sv @@
// Channel  | Direction | Handshake                 | Word
// ---------+-----------+---------------------------+------------
// in       | input     | i_in_valid / o_in_stall   | t_in_word
// out      | output    | o_out_valid / i_out_stall | t_out_word
// cfg      | input     | APB psel/penable/pready   | 2 x 16 bits
//
// One word a cycle while the output is not stalled: a word is held in
// the input register, is processed in a single pass and lands in the
// output register, from which the result is offered.
// Synchronous active-low reset clears the valid flags, scan state, samples and new flags.
// A stalled output holds the input register; one word stays buffered.
module adc_channel_scan_sequencer
    import acss_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      advance;
    logic      accept;
    t_cfg      cfg;
    t_out_word result;

    // Word moves on when the output register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_word <= i_in_word;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    acss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    acss_core #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

endmodule

@@ sv/acss_cfg.sv @@
module acss_cfg
    import acss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [MS_W-1:0] r_timeout;
    logic [MS_W-1:0] r_gap;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_gap     <= GAP_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_TIMEOUT: r_timeout <= pwdata[MS_W-1:0];
                REG_GAP:     r_gap     <= pwdata[MS_W-1:0];
                default:     ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_TIMEOUT: prdata = APB_DATA_W'(r_timeout);
            REG_GAP:     prdata = APB_DATA_W'(r_gap);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.timeout_ms = r_timeout;
    assign o_cfg.gap_ms     = r_gap;

endmodule

@@ sv/acss_core.sv @@
module acss_core
    import acss_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CNT_W-1:0]  CH_END   = CNT_W'(CHANNELS);
    localparam logic [CHAN_W:0]   CH_END_R = (CHAN_W + 1)'(CHANNELS);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [MS_W-1:0]        r_elapsed, n_elapsed;
    logic [SAMPLE_BITS-1:0] r_store [CHANNELS];
    logic [CHANNELS-1:0]    r_new;

    logic                    idx_end;
    logic                    rd_in_range;
    logic [IDX_W-1:0]        wr_idx;
    logic [IDX_W-1:0]        rd_idx;
    logic [SAMPLE_W_MAX-1:0] smp_ext;
    logic [SAMPLE_W_MAX-1:0] rd_ext;
    logic                    do_store;
    logic                    do_clear;
    logic                    started, complete, tmo;
    logic [1:0]              phase_code;

    assign idx_end     = (r_idx >= CH_END);
    assign rd_in_range = ({1'b0, i_word.read_channel} < CH_END_R);
    assign wr_idx      = r_idx[IDX_W-1:0];
    assign rd_idx      = i_word.read_channel[IDX_W-1:0];
    assign smp_ext     = SAMPLE_W_MAX'(i_word.sample);
    assign rd_ext      = SAMPLE_W_MAX'(r_store[rd_idx]);

    // Next state and result for the word at hand
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_elapsed = r_elapsed;
        started   = 1'b0;
        complete  = 1'b0;
        tmo       = 1'b0;
        do_store  = 1'b0;
        do_clear  = 1'b0;
        unique case (i_word.cmd)
            CMD_POLL: begin
                unique case (r_state)
                    ST_IDLE: begin
                        n_idx   = '0;
                        n_state = ST_START;
                    end
                    ST_START: begin
                        n_elapsed = '0;
                        if (idx_end) begin
                            complete = 1'b1;
                            n_state  = ST_DONE;
                        end else begin
                            started = 1'b1;
                            n_state = ST_WAIT;
                        end
                    end
                    ST_WAIT: begin
                        if (r_elapsed > i_cfg.timeout_ms) begin
                            tmo     = 1'b1;
                            n_state = ST_IDLE;
                        end
                    end
                    ST_DONE: begin
                        if (r_elapsed > i_cfg.gap_ms) begin
                            n_state = ST_IDLE;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            CMD_TICK: begin
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end
            CMD_DONE: begin
                // completion is taken in any phase
                if (idx_end) begin
                    n_state = ST_IDLE;
                end else begin
                    do_store = 1'b1;
                    n_idx    = r_idx + 1'b1;
                    n_state  = ST_START;
                end
            end
            CMD_READ: begin
                do_clear = rd_in_range && i_word.clear_new;
            end
            default: ;
        endcase
    end

    // Reported phase code
    always_comb begin
        unique case (n_state)
            ST_IDLE:  phase_code = PHASE_IDLE;
            ST_START: phase_code = PHASE_START;
            ST_WAIT:  phase_code = PHASE_WAIT;
            ST_DONE:  phase_code = PHASE_DONE;
            default:  phase_code = PHASE_IDLE;
        endcase
    end

    // Result word
    always_comb begin
        o_result                    = '0;
        o_result.start_conversion   = started;
        o_result.conversion_channel = CHAN_W'(n_idx);
        o_result.phase              = phase_code;
        o_result.scan_complete      = complete;
        o_result.timed_out          = tmo;
        if (i_word.cmd == CMD_READ && rd_in_range) begin
            o_result.read_sample = rd_ext[SAMPLE_W-1:0];
            o_result.read_new    = r_new[rd_idx];
        end
    end

    // Scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_elapsed <= '0;
        end else if (i_fire) begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_elapsed <= n_elapsed;
        end
    end

    // Sample store and new flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_store[i] <= '0;
            end
            r_new <= '0;
        end else if (i_fire) begin
            if (do_store) begin
                r_store[wr_idx] <= smp_ext[SAMPLE_BITS-1:0];
                r_new[wr_idx]   <= 1'b1;
            end
            if (do_clear) begin
                r_new[rd_idx] <= 1'b0;
            end
        end
    end

endmodule
